// ===== rtl/core/radix40_symbol_codec_top_defines.svh =====
// Assertion macros for the radix-40 codec.
`ifndef RADIX40_SYMBOL_CODEC_TOP_DEFINES_SVH
`define RADIX40_SYMBOL_CODEC_TOP_DEFINES_SVH
`ifndef SYNTH
`define R40_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("r40 check failed");
`define R40_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("r40 check failed");
`else
`define R40_IMPLY(lbl, ante, cons)
`define R40_NEXT(lbl, ante, cons)
`endif
`endif

// ===== rtl/core/r40_pkg.sv =====
package r40_pkg;

  localparam int NCHAR     = 6;
  localparam int NPAIR     = NCHAR / 2;
  localparam int NSTAGE    = 5;
  localparam int RADIX     = 40;
  localparam int CHAR_W    = 8;
  localparam int OCHAR_W   = 7;
  localparam int CODE_W    = 6;
  localparam int PAIR_W    = 11;
  localparam int UPPER_W   = 22;
  localparam int PACKED_W  = 32;
  localparam int LEN_W     = 3;
  localparam int HI_W      = 17;
  localparam int LO_W      = 16;
  localparam int TQ_W      = 11;

  localparam logic [5:0]  MIN_FIRST_CODE = 6'd11;
  localparam logic [5:0]  CODE_DASH      = 6'd37;
  localparam logic [5:0]  CODE_STAR      = 6'd38;
  localparam logic [5:0]  CODE_DOLLAR    = 6'd39;
  localparam logic [7:0]  CASE_BIT       = 8'h20;
  localparam logic [31:0] MIN_PACKED     = 32'd1126400000;  // 11 * 40^5

  // x / 64000 = (x >> 9) / 125, reciprocal exact for 23-bit operands
  localparam logic [23:0] HI_RECIP   = 24'd8589935;
  localparam int          HI_SHIFT   = 30;
  localparam logic [31:0] LO_SPAN    = 32'd64000;
  // n / 40 = (n >> 3) / 5, reciprocal exact for 17-bit operands
  localparam logic [13:0] DIV40_RECIP = 14'd13108;

  typedef enum logic {
    CMD_ENCODE = 1'b0,
    CMD_DECODE = 1'b1
  } cmd_t;

  typedef struct packed {
    logic                             command;
    logic [NCHAR-1:0][CHAR_W-1:0]     chars;
    logic                             longer_than_six;
    logic [PACKED_W-1:0]              packed_in;
  } item_t;

  typedef struct packed {
    logic [NSTAGE-1:0] load;
    logic [NSTAGE-1:0] valid;
  } pipe_ctl_t;

  typedef struct packed {
    logic              ok;
    logic [CODE_W-1:0] code;
  } code_t;

  function automatic code_t code_of(input logic [CHAR_W-1:0] b);
    code_t r;
    logic [CHAR_W-1:0] f;
    f = b | CASE_BIT;
    r.ok = 1'b1;
    r.code = '0;
    if (b == '0) begin
      r.code = '0;
    end else if (b inside {[8'h30:8'h39]}) begin
      r.code = CODE_W'(b - 8'h2F);
    end else if (b == 8'h2D) begin
      r.code = CODE_DASH;
    end else if (b == 8'h2A) begin
      r.code = CODE_STAR;
    end else if (b == 8'h24) begin
      r.code = CODE_DOLLAR;
    end else if (!b[7] && (f inside {[8'h61:8'h7A]})) begin
      r.code = CODE_W'(f - 8'h56);
    end else begin
      r.ok = 1'b0;
    end
    return r;
  endfunction

  function automatic logic [OCHAR_W-1:0] char_of(input logic [CODE_W-1:0] d);
    logic [OCHAR_W-1:0] c;
    case (d) inside
      [6'd1:6'd10]:  c = OCHAR_W'(d) + 7'h2F;
      [6'd11:6'd36]: c = OCHAR_W'(d) + 7'h56;
      CODE_DASH:     c = 7'h2D;
      CODE_STAR:     c = 7'h2A;
      CODE_DOLLAR:   c = 7'h24;
      default:       c = '0;
    endcase
    return c;
  endfunction

  function automatic logic [11:0] div40(input logic [HI_W-1:0] n);
    logic [27:0] p;
    p = 28'(n[HI_W-1:3]) * 28'(DIV40_RECIP);
    return p[27:16];
  endfunction

endpackage

// ===== rtl/core/r40_if.sv =====
interface r40_item_if;
  import r40_pkg::*;
  logic                valid;
  logic                ready;
  logic                command;
  logic [CHAR_W-1:0]   char_0;
  logic [CHAR_W-1:0]   char_1;
  logic [CHAR_W-1:0]   char_2;
  logic [CHAR_W-1:0]   char_3;
  logic [CHAR_W-1:0]   char_4;
  logic [CHAR_W-1:0]   char_5;
  logic                longer_than_six;
  logic [PACKED_W-1:0] packed_in;

  modport source (output valid, command, char_0, char_1, char_2, char_3, char_4, char_5,
                  longer_than_six, packed_in, input ready);
  modport sink (input valid, command, char_0, char_1, char_2, char_3, char_4, char_5,
                longer_than_six, packed_in, output ready);
endinterface

interface r40_result_if;
  import r40_pkg::*;
  logic                valid;
  logic                ready;
  logic [PACKED_W-1:0] packed_out;
  logic                name_valid;
  logic [OCHAR_W-1:0]  out_char_0;
  logic [OCHAR_W-1:0]  out_char_1;
  logic [OCHAR_W-1:0]  out_char_2;
  logic [OCHAR_W-1:0]  out_char_3;
  logic [OCHAR_W-1:0]  out_char_4;
  logic [OCHAR_W-1:0]  out_char_5;
  logic [LEN_W-1:0]    decoded_length;

  modport source (output valid, packed_out, name_valid, out_char_0, out_char_1, out_char_2,
                  out_char_3, out_char_4, out_char_5, decoded_length, input ready);
  modport sink (input valid, packed_out, name_valid, out_char_0, out_char_1, out_char_2,
                out_char_3, out_char_4, out_char_5, decoded_length, output ready);
endinterface

// ===== rtl/core/radix40_symbol_codec_top.sv =====
// Radix-40 name codec.
// item channel: one word per name. command 0 packs char_0..char_5 (a zero byte
// ends the name, longer_than_six marks a name that runs past six characters)
// into packed_out with name_valid; command 1 unpacks packed_in into
// out_char_0..out_char_5 and decoded_length. Fields of the unused direction
// come back as zero.
// result channel: exactly one word per accepted item, in order.
// Each item passes through a five-stage pipeline (input register, three
// arithmetic stages, result register); the decode path splits the value by
// 40^3 with a reciprocal multiply, then peels digits with small divide-by-40
// steps spread over the later stages.
// Throughput: one item per cycle while the receiver keeps ready high.
// When the receiver stalls, the pipeline fills and the bubbles close up; ready
// on the item channel drops only once all five stages hold a word.
// Reset (rst, synchronous) empties the pipeline; no result is pending after it.
`include "radix40_symbol_codec_top_defines.svh"

module radix40_symbol_codec_top (
  input  logic          clk,
  input  logic          rst,
  r40_item_if.sink      item,
  r40_result_if.source  result
);
  import r40_pkg::*;

  pipe_ctl_t                     ctl;
  item_t                         stage_in;
  logic [NCHAR-1:0][OCHAR_W-1:0] out_char;

  r40_pipe u_pipe (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (item.valid),
    .out_ready (result.ready),
    .ctl       (ctl)
  );

  always_ff @(posedge clk) begin
    if (ctl.load[0]) begin
      stage_in.command         <= item.command;
      stage_in.chars[0]        <= item.char_0;
      stage_in.chars[1]        <= item.char_1;
      stage_in.chars[2]        <= item.char_2;
      stage_in.chars[3]        <= item.char_3;
      stage_in.chars[4]        <= item.char_4;
      stage_in.chars[5]        <= item.char_5;
      stage_in.longer_than_six <= item.longer_than_six;
      stage_in.packed_in       <= item.packed_in;
    end
  end

  r40_enc u_enc (
    .clk        (clk),
    .ctl        (ctl),
    .item       (stage_in),
    .packed_out (result.packed_out),
    .name_valid (result.name_valid)
  );

  r40_dec u_dec (
    .clk            (clk),
    .ctl            (ctl),
    .item           (stage_in),
    .out_char       (out_char),
    .decoded_length (result.decoded_length)
  );

  assign item.ready        = ctl.load[0];
  assign result.valid      = ctl.valid[NSTAGE-1];
  assign result.out_char_0 = out_char[0];
  assign result.out_char_1 = out_char[1];
  assign result.out_char_2 = out_char[2];
  assign result.out_char_3 = out_char[3];
  assign result.out_char_4 = out_char[4];
  assign result.out_char_5 = out_char[5];

  `R40_NEXT(a_accept_fills, item.valid && item.ready, ctl.valid[0])
  `R40_IMPLY(a_packed_floor, result.valid && result.name_valid, result.packed_out >= MIN_PACKED)
  `R40_IMPLY(a_one_direction, result.valid && result.name_valid, result.decoded_length == '0)
  `R40_IMPLY(a_len_range, result.valid, result.decoded_length <= LEN_W'(NCHAR))
  `R40_IMPLY(a_empty_decode, result.valid && result.out_char_0 == '0,
             result.decoded_length == '0)

endmodule

// ===== rtl/core/r40_pipe.sv =====
module r40_pipe (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                out_ready,
  output r40_pkg::pipe_ctl_t  ctl
);
  import r40_pkg::*;

  logic [NSTAGE-1:0] valid;
  logic [NSTAGE-1:0] valid_next;
  logic [NSTAGE-1:0] load;

  // a stage loads when it is empty or its word moves on this cycle
  always_comb begin
    load[NSTAGE-1] = !valid[NSTAGE-1] || out_ready;
    for (int k = NSTAGE - 2; k >= 0; k--) begin
      load[k] = !valid[k] || load[k+1];
    end
  end

  always_comb begin
    valid_next = valid;
    if (load[0]) valid_next[0] = in_valid;
    for (int k = 1; k < NSTAGE; k++) begin
      if (load[k]) valid_next[k] = valid[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      valid <= valid_next;
    end
  end

  assign ctl.load  = load;
  assign ctl.valid = valid;

endmodule

// ===== rtl/core/r40_enc.sv =====
module r40_enc (
  input  logic                            clk,
  input  r40_pkg::pipe_ctl_t              ctl,
  input  r40_pkg::item_t                  item,
  output logic [r40_pkg::PACKED_W-1:0]    packed_out,
  output logic                            name_valid
);
  import r40_pkg::*;

  logic [NCHAR-1:0][CODE_W-1:0] code;
  logic [NCHAR-1:0][CODE_W-1:0] code_next;
  logic                         ok2;
  logic                         ok2_next;
  logic [NPAIR-1:0][PAIR_W-1:0] pair;
  logic [NPAIR-1:0][PAIR_W-1:0] pair_next;
  logic                         ok3;
  logic [UPPER_W-1:0]           upper;
  logic [PAIR_W-1:0]            tail;
  logic                         ok4;

  // digit codes; everything past the first NUL becomes zero, and all codes are zero for an invalid name
  always_comb begin
    code_t cd;
    logic  alive;
    alive    = 1'b1;
    ok2_next = (item.command == CMD_ENCODE);
    for (int i = 0; i < NCHAR; i++) begin
      cd = code_of(item.chars[i]);
      if (alive && !cd.ok) ok2_next = 1'b0;
      if (i == 0 && cd.code < MIN_FIRST_CODE) ok2_next = 1'b0;
      code_next[i] = alive ? cd.code : '0;
      alive = alive && (item.chars[i] != '0);
    end
    if (alive && item.longer_than_six) ok2_next = 1'b0;
    if (!ok2_next) code_next = '0;
  end

  always_comb begin
    for (int j = 0; j < NPAIR; j++) begin
      pair_next[j] = PAIR_W'(code[2*j]) * PAIR_W'(RADIX) + PAIR_W'(code[2*j+1]);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load[1]) begin
      code <= code_next;
      ok2  <= ok2_next;
    end
    if (ctl.load[2]) begin
      pair <= pair_next;
      ok3  <= ok2;
    end
    if (ctl.load[3]) begin
      upper <= UPPER_W'(pair[0]) * UPPER_W'(RADIX * RADIX) + UPPER_W'(pair[1]);
      tail  <= pair[2];
      ok4   <= ok3;
    end
    if (ctl.load[4]) begin
      packed_out <= PACKED_W'(upper) * PACKED_W'(RADIX * RADIX) + PACKED_W'(tail);
      name_valid <= ok4;
    end
  end

endmodule

// ===== rtl/core/r40_dec.sv =====
module r40_dec (
  input  logic                                          clk,
  input  r40_pkg::pipe_ctl_t                            ctl,
  input  r40_pkg::item_t                                item,
  output logic [r40_pkg::NCHAR-1:0][r40_pkg::OCHAR_W-1:0] out_char,
  output logic [r40_pkg::LEN_W-1:0]                     decoded_length
);
  import r40_pkg::*;

  logic [46:0]          hi_prod;
  logic [HI_W-1:0]      hi;
  logic [PACKED_W-1:0]  x2;
  logic                 dec2;

  logic [LO_W-1:0]      lo;
  logic [TQ_W-1:0]      t_hi;
  logic [CODE_W-1:0]    d2_3;
  logic                 dec3;
  logic [TQ_W-1:0]      t_hi_next;
  logic [TQ_W-1:0]      t_lo_next;
  logic [CODE_W-1:0]    d0_next;

  logic [TQ_W-1:0]      t_lo;
  logic [CODE_W-1:0]    d0;
  logic [CODE_W-1:0]    d1;
  logic [CODE_W-1:0]    d2;
  logic [CODE_W-1:0]    d5;
  logic                 dec4;

  logic [CODE_W-1:0]    d3;
  logic [NCHAR-1:0][CODE_W-1:0]  digit;
  logic [NCHAR-1:0][OCHAR_W-1:0] out_char_next;
  logic [LEN_W-1:0]              len_next;

  // upper three digits from x / 40^3, lower three from the remainder
  assign hi_prod   = 47'(item.packed_in[PACKED_W-1:9]) * 47'(HI_RECIP);
  assign t_hi_next = TQ_W'(div40(hi));
  assign t_lo_next = TQ_W'(div40(HI_W'(lo)));
  assign d0_next   = CODE_W'(div40(HI_W'(t_hi)));
  assign d3        = CODE_W'(div40(HI_W'(t_lo)));

  always_comb begin
    logic go;
    digit[0] = d0;
    digit[1] = d1;
    digit[2] = d2;
    digit[3] = d3;
    digit[4] = CODE_W'(t_lo - TQ_W'(d3) * TQ_W'(RADIX));
    digit[5] = d5;
    go       = dec4;
    len_next = '0;
    for (int i = 0; i < NCHAR; i++) begin
      go = go && (char_of(digit[i]) != '0);
      out_char_next[i] = go ? char_of(digit[i]) : '0;
      len_next = len_next + LEN_W'(go);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load[1]) begin
      hi   <= hi_prod[46:HI_SHIFT];
      x2   <= item.packed_in;
      dec2 <= (item.command == CMD_DECODE);
    end
    if (ctl.load[2]) begin
      lo   <= LO_W'(x2 - PACKED_W'(hi) * LO_SPAN);
      t_hi <= t_hi_next;
      d2_3 <= CODE_W'(hi - HI_W'(t_hi_next) * HI_W'(RADIX));
      dec3 <= dec2;
    end
    if (ctl.load[3]) begin
      t_lo <= t_lo_next;
      d5   <= CODE_W'(lo - LO_W'(t_lo_next) * LO_W'(RADIX));
      d0   <= d0_next;
      d1   <= CODE_W'(t_hi - TQ_W'(d0_next) * TQ_W'(RADIX));
      d2   <= d2_3;
      dec4 <= dec3;
    end
    if (ctl.load[4]) begin
      out_char       <= out_char_next;
      decoded_length <= len_next;
    end
  end

endmodule
